FILE: sv/kcc_pkg.sv
// Constants, types and lookup functions of the climate classifier.
package kcc_pkg;

  localparam int MonthW  = 4;
  localparam int TempW   = 14;
  localparam int PrecW   = 15;
  localparam int RowW    = 9;
  localparam int SumW    = 18;
  localparam int CountW  = 4;
  localparam int CodeW   = 6;
  localparam int AlphaW  = 8;
  localparam int RegimeW = 2;
  localparam int CalcW   = 25;

  localparam logic [MonthW-1:0] MONTH_LAST      = 4'd11;
  localparam logic [MonthW-1:0] MONTH_SEASON_LO = 4'd3;
  localparam logic [MonthW-1:0] MONTH_SEASON_HI = 4'd8;
  localparam logic [RowW-1:0]   ROW_NORTH_MAX   = 9'd180;

  localparam logic signed [SumW:0] TSUM_MAX = 19'sd131071;
  localparam logic signed [SumW:0] TSUM_MIN = -19'sd131072;
  localparam logic [CountW-1:0]    COUNT_MAX = 4'd15;

  localparam logic signed [TempW-1:0] T_WARM   = 14'sd1000;
  localparam logic signed [TempW-1:0] T_FROST  = 14'sd0;
  localparam logic signed [TempW-1:0] T_TROP   = 14'sd1800;
  localparam logic signed [TempW-1:0] T_COLD   = -14'sd300;
  localparam logic signed [TempW-1:0] T_SEVERE = -14'sd3800;
  localparam logic signed [TempW-1:0] T_HOT    = 14'sd2200;

  localparam logic [PrecW-1:0] P_WET     = 15'd600;
  localparam logic [PrecW-1:0] P_DRY_SUM = 15'd400;

  localparam logic signed [CalcW-1:0] B_OFS_SUMMER = 25'sd16800;
  localparam logic signed [CalcW-1:0] B_OFS_CONST  = 25'sd8400;
  localparam logic signed [CalcW-1:0] B_OFS_WINTER = 25'sd0;
  localparam logic signed [CalcW-1:0] AM_LIMIT     = 25'sd25000;
  localparam logic signed [CalcW-1:0] AM_SLOPE     = 25'sd25;

  localparam logic [RegimeW-1:0] REGIME_CONST  = 2'd0;
  localparam logic [RegimeW-1:0] REGIME_SUMMER = 2'd1;
  localparam logic [RegimeW-1:0] REGIME_WINTER = 2'd2;

  localparam logic [CodeW-1:0] CLS_AF = 6'd11;
  localparam logic [CodeW-1:0] CLS_AM = 6'd12;
  localparam logic [CodeW-1:0] CLS_AW = 6'd13;
  localparam logic [CodeW-1:0] CLS_BW = 6'd20;
  localparam logic [CodeW-1:0] CLS_BS = 6'd25;
  localparam logic [CodeW-1:0] CLS_CFA = 6'd31;
  localparam logic [CodeW-1:0] CLS_CFB = 6'd32;
  localparam logic [CodeW-1:0] CLS_CFC = 6'd33;
  localparam logic [CodeW-1:0] CLS_CSA = 6'd34;
  localparam logic [CodeW-1:0] CLS_CSB = 6'd35;
  localparam logic [CodeW-1:0] CLS_CSC = 6'd36;
  localparam logic [CodeW-1:0] CLS_CWA = 6'd37;
  localparam logic [CodeW-1:0] CLS_CWB = 6'd38;
  localparam logic [CodeW-1:0] CLS_CWC = 6'd39;
  localparam logic [CodeW-1:0] CLS_DFA = 6'd41;
  localparam logic [CodeW-1:0] CLS_DFB = 6'd42;
  localparam logic [CodeW-1:0] CLS_DFD = 6'd44;
  localparam logic [CodeW-1:0] CLS_DSA = 6'd45;
  localparam logic [CodeW-1:0] CLS_DSB = 6'd46;
  localparam logic [CodeW-1:0] CLS_DSC = 6'd47;
  localparam logic [CodeW-1:0] CLS_DSD = 6'd48;
  localparam logic [CodeW-1:0] CLS_DWA = 6'd49;
  localparam logic [CodeW-1:0] CLS_DWB = 6'd50;
  localparam logic [CodeW-1:0] CLS_DWC = 6'd51;
  localparam logic [CodeW-1:0] CLS_DWD = 6'd52;
  localparam logic [CodeW-1:0] CLS_EF = 6'd61;
  localparam logic [CodeW-1:0] CLS_ET = 6'd62;

  localparam logic [CodeW-1:0] C_BASE = 6'd30;
  localparam logic [CodeW-1:0] D_BASE = 6'd40;
  localparam logic [CodeW-1:0] OFS_MOIST  = 6'd1;
  localparam logic [CodeW-1:0] OFS_DRY_S  = 6'd4;
  localparam logic [CodeW-1:0] OFS_DRY_W  = 6'd7;
  localparam logic [CodeW-1:0] OFS_WARM   = 6'd1;
  localparam logic [CodeW-1:0] OFS_COOL   = 6'd2;
  localparam logic [CodeW-1:0] OFS_FRIGID = 6'd10;

  // raw D codes before renumbering
  localparam logic [CodeW-1:0] RAW_DFD = 6'd51;
  localparam logic [CodeW-1:0] RAW_DSA = 6'd44;
  localparam logic [CodeW-1:0] RAW_DSB = 6'd45;
  localparam logic [CodeW-1:0] RAW_DSC = 6'd46;
  localparam logic [CodeW-1:0] RAW_DSD = 6'd54;
  localparam logic [CodeW-1:0] RAW_DWA = 6'd47;
  localparam logic [CodeW-1:0] RAW_DWB = 6'd48;
  localparam logic [CodeW-1:0] RAW_DWC = 6'd49;
  localparam logic [CodeW-1:0] RAW_DWD = 6'd57;

  typedef struct packed {
    logic signed [TempW-1:0] tmin;
    logic signed [TempW-1:0] tmax;
    logic signed [SumW-1:0]  tsum;
    logic [CountW-1:0]       warm;
    logic [PrecW-1:0]        pmin;
    logic [MonthW-1:0]       dmonth;
    logic [SumW-1:0]         annual;
    logic [SumW-1:0]         summer;
    logic [SumW-1:0]         winter;
    logic [PrecW-1:0]        speak;
    logic [PrecW-1:0]        wpeak;
  } stats_t;

  localparam stats_t STATS_RESET = '{
    tmin:   14'sd8191,
    tmax:   -14'sd8192,
    tsum:   18'sd0,
    warm:   4'd0,
    pmin:   15'd32767,
    dmonth: 4'd0,
    annual: 18'd0,
    summer: 18'd0,
    winter: 18'd0,
    speak:  15'd0,
    wpeak:  15'd0
  };

  function automatic logic [CodeW-1:0] renumber_d(input logic [CodeW-1:0] c);
    case (c)
      RAW_DFD: return CLS_DFD;
      RAW_DSA: return CLS_DSA;
      RAW_DSB: return CLS_DSB;
      RAW_DSC: return CLS_DSC;
      RAW_DSD: return CLS_DSD;
      RAW_DWA: return CLS_DWA;
      RAW_DWB: return CLS_DWB;
      RAW_DWC: return CLS_DWC;
      RAW_DWD: return CLS_DWD;
      default: return c;
    endcase
  endfunction

  function automatic logic [AlphaW-1:0] alpha_of(input logic [CodeW-1:0] c);
    case (c)
      CLS_AF, CLS_BW:                    return 8'd200;
      CLS_AM, CLS_CSA, CLS_CSB:          return 8'd165;
      CLS_AW:                            return 8'd140;
      CLS_BS:                            return 8'd185;
      CLS_CFA, CLS_CFB:                  return 8'd145;
      CLS_CWA:                           return 8'd137;
      CLS_CSC, CLS_CWB, CLS_CWC, CLS_DWA: return 8'd126;
      CLS_DFA, CLS_DFB, CLS_DWB:         return 8'd130;
      CLS_CFC, CLS_DSA:                  return 8'd120;
      CLS_DSD, CLS_DWD:                  return 8'd115;
      CLS_EF:                            return 8'd100;
      default:                           return 8'd110;
    endcase
  endfunction

endpackage

FILE: sv/koppen_climate_classifier.sv
// Climate classifier: monthly statistics per grid cell and class decision.
//
//  channel  direction  handshake                word fields
//  input    in         valid / stall            month, temperature, precipitation, grid_row
//  result   out        result_valid / result_stall  class_code, alpha_hundredths, rain_regime
//
//  One word per cycle is taken unless stall is high; each passes an input register, then
//  the statistics update. The month 11 word leaves a snapshot that is classified into the
//  result register once that register is free; a held result keeps the snapshot waiting.
//  rst clears the statistics and all valid flags; no clearing pass follows.
//  A held result stalls the input only once the snapshot is full and a month 11 word waits.
module koppen_climate_classifier
  import kcc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid,
  output logic                      stall,
  input  logic [MonthW-1:0]         month,
  input  logic signed [TempW-1:0]   temperature,
  input  logic [PrecW-1:0]          precipitation,
  input  logic [RowW-1:0]           grid_row,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [CodeW-1:0]          class_code,
  output logic [AlphaW-1:0]         alpha_hundredths,
  output logic [RegimeW-1:0]        rain_regime
);

  logic                    in_vld;
  logic [MonthW-1:0]       in_month;
  logic signed [TempW-1:0] in_temp;
  logic [PrecW-1:0]        in_prec;
  logic [RowW-1:0]         in_row;

  stats_t acc;
  stats_t acc_next;
  stats_t snap;
  logic   snap_north;
  logic   snap_vld;

  logic in_north;
  logic in_mid;
  logic in_summer;
  logic in_last;
  logic out_free;
  logic snap_free;
  logic take;

  logic signed [SumW:0]  tsum_wide;
  logic [SumW:0]         annual_wide;
  logic [SumW:0]         summer_wide;
  logic [SumW:0]         winter_wide;

  // handshake
  always_comb begin
    in_last   = (in_month == MONTH_LAST);
    out_free  = !result_valid || !result_stall;
    snap_free = !snap_vld || out_free;
    take      = in_vld && (!in_last || snap_free);
    stall     = in_vld && !take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!stall) begin
      in_vld <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && !stall) begin
      in_month <= month;
      in_temp  <= temperature;
      in_prec  <= precipitation;
      in_row   <= grid_row;
    end
  end

  // statistics update
  always_comb begin
    in_north  = (in_row <= ROW_NORTH_MAX);
    in_mid    = in_month inside {[MONTH_SEASON_LO:MONTH_SEASON_HI]};
    in_summer = in_north ? in_mid : !in_mid;

    acc_next = acc;
    if (in_temp >= T_WARM && acc.warm != COUNT_MAX) begin
      acc_next.warm = acc.warm + 4'd1;
    end
    if (in_temp < acc.tmin) begin
      acc_next.tmin = in_temp;
    end
    if (in_temp > acc.tmax) begin
      acc_next.tmax = in_temp;
    end
    if (in_prec < acc.pmin) begin
      acc_next.pmin   = in_prec;
      acc_next.dmonth = in_month;
    end

    tsum_wide = 19'(acc.tsum) + 19'(in_temp);
    if (tsum_wide > TSUM_MAX) begin
      acc_next.tsum = TSUM_MAX[SumW-1:0];
    end else if (tsum_wide < TSUM_MIN) begin
      acc_next.tsum = TSUM_MIN[SumW-1:0];
    end else begin
      acc_next.tsum = tsum_wide[SumW-1:0];
    end

    annual_wide = {1'b0, acc.annual} + 19'(in_prec);
    summer_wide = {1'b0, acc.summer} + 19'(in_prec);
    winter_wide = {1'b0, acc.winter} + 19'(in_prec);
    acc_next.annual = annual_wide[SumW] ? '1 : annual_wide[SumW-1:0];
    if (in_summer) begin
      acc_next.summer = summer_wide[SumW] ? '1 : summer_wide[SumW-1:0];
      if (in_prec > acc.speak) begin
        acc_next.speak = in_prec;
      end
    end else begin
      acc_next.winter = winter_wide[SumW] ? '1 : winter_wide[SumW-1:0];
      if (in_prec > acc.wpeak) begin
        acc_next.wpeak = in_prec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= STATS_RESET;
    end else if (take) begin
      acc <= in_last ? STATS_RESET : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_vld <= 1'b0;
    end else if (take && in_last) begin
      snap_vld <= 1'b1;
    end else if (out_free) begin
      snap_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      snap       <= acc_next;
      snap_north <= in_north;
    end
  end

  // classification
  logic signed [CalcW-1:0] s_w;
  logic signed [CalcW-1:0] ts_w;
  logic signed [CalcW-1:0] s12;
  logic signed [CalcW-1:0] b_ofs;
  logic signed [CalcW-1:0] pmin_w;
  logic [RegimeW-1:0]      regime;
  logic                    dry_mid;
  logic                    summer_dry;
  logic [CodeW-1:0]        code_raw;
  logic [CodeW-1:0]        code;

  always_comb begin
    s_w    = 25'(snap.annual);
    ts_w   = 25'(snap.tsum);
    pmin_w = 25'(snap.pmin);
    s12    = s_w * 25'sd12;

    if (25'(snap.winter) * 25'sd3 >= s_w * 25'sd2) begin
      regime = REGIME_WINTER;
      b_ofs  = B_OFS_WINTER;
    end else if (25'(snap.summer) * 25'sd3 >= s_w * 25'sd2) begin
      regime = REGIME_SUMMER;
      b_ofs  = B_OFS_SUMMER;
    end else begin
      regime = REGIME_CONST;
      b_ofs  = B_OFS_CONST;
    end

    dry_mid    = snap.dmonth inside {[MONTH_SEASON_LO:MONTH_SEASON_HI]};
    summer_dry = snap_north ? dry_mid : !dry_mid;

    code_raw = (snap.tmin <= T_COLD) ? D_BASE : C_BASE;
    if (summer_dry) begin
      if ((25'(snap.pmin) * 25'sd3 < 25'(snap.wpeak)) && (snap.pmin < P_DRY_SUM)) begin
        code_raw = code_raw + OFS_DRY_S;
      end else begin
        code_raw = code_raw + OFS_MOIST;
      end
    end else if (25'(snap.pmin) * 25'sd10 < 25'(snap.speak)) begin
      code_raw = code_raw + OFS_DRY_W;
    end else begin
      code_raw = code_raw + OFS_MOIST;
    end
    if (snap.tmax < T_HOT) begin
      if (snap.warm >= 4'd4) begin
        code_raw = code_raw + OFS_WARM;
      end else if (snap.tmin > T_SEVERE) begin
        code_raw = code_raw + OFS_COOL;
      end else begin
        code_raw = code_raw + OFS_FRIGID;
      end
    end

    if (snap.tmax < T_WARM) begin
      code = (snap.tmax < T_FROST) ? CLS_EF : CLS_ET;
    end else if (s12 < (ts_w + b_ofs) * 25'sd2) begin
      code = (s12 > ts_w + b_ofs) ? CLS_BS : CLS_BW;
    end else if (snap.tmin >= T_TROP) begin
      if (snap.pmin >= P_WET) begin
        code = CLS_AF;
      end else if (s_w >= AM_LIMIT - AM_SLOPE * pmin_w) begin
        code = CLS_AM;
      end else begin
        code = CLS_AW;
      end
    end else if (code_raw > D_BASE) begin
      code = renumber_d(code_raw);
    end else begin
      code = code_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= snap_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_vld) begin
      class_code       <= code;
      alpha_hundredths <= alpha_of(code);
      rain_regime      <= regime;
    end
  end

  a_snap_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(snap_vld) |-> $past(in_vld && in_month == MONTH_LAST))
    else $error("snapshot loaded without a closing month word");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && in_last) |=> (acc.annual == '0 && acc.warm == '0 && acc.tsum == '0))
    else $error("statistics not cleared after closing month");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (class_code >= CLS_AF && class_code <= CLS_ET))
    else $error("class code out of range");

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (alpha_hundredths >= 8'd100 && alpha_hundredths <= 8'd200))
    else $error("alpha out of range");

  a_regime_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (rain_regime == REGIME_CONST || rain_regime == REGIME_SUMMER ||
                      rain_regime == REGIME_WINTER))
    else $error("invalid rain regime");

  a_no_lost_snap: assert property (@(posedge clk) disable iff (rst)
    (snap_vld && !out_free) |=> snap_vld)
    else $error("pending snapshot dropped");

endmodule

FILE: bench/climate_ledger_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class for the climate classifier: statistics, class prediction, result checks.
package climate_ledger_pkg;
  import kcc_pkg::*;

  localparam longint RAIN_CEIL     = (longint'(1) << SumW) - 1;
  localparam int     WARM_MONTHS_B = 4;

  typedef enum logic [1:0] {LETTER_F, LETTER_S, LETTER_W} wet_letter_t;
  typedef enum logic [1:0] {LETTER_A, LETTER_B, LETTER_C, LETTER_D} heat_letter_t;

  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [AlphaW-1:0]  alpha;
    logic [RegimeW-1:0] regime;
  } verdict_t;

  class climate_ledger;
    logic signed [TempW-1:0] t_lo;
    logic signed [TempW-1:0] t_hi;
    logic signed [SumW-1:0]  t_total;
    logic [CountW-1:0]       warm_months;
    logic [PrecW-1:0]        p_lo;
    logic [MonthW-1:0]       p_lo_month;
    logic [SumW-1:0]         rain_all;
    logic [SumW-1:0]         rain_summer;
    logic [SumW-1:0]         rain_winter;
    logic [PrecW-1:0]        peak_summer;
    logic [PrecW-1:0]        peak_winter;
    verdict_t                verdicts_due[$];
    bit                      seen_class[64];
    int                      words;
    int                      checked;
    int                      faults;

    function new();
      clear();
    endfunction

    function void clear();
      t_lo        = STATS_RESET.tmin;
      t_hi        = STATS_RESET.tmax;
      t_total     = STATS_RESET.tsum;
      warm_months = STATS_RESET.warm;
      p_lo        = STATS_RESET.pmin;
      p_lo_month  = STATS_RESET.dmonth;
      rain_all    = STATS_RESET.annual;
      rain_summer = STATS_RESET.summer;
      rain_winter = STATS_RESET.winter;
      peak_summer = STATS_RESET.speak;
      peak_winter = STATS_RESET.wpeak;
    endfunction

    function bit in_season(logic [MonthW-1:0] m);
      return m >= MONTH_SEASON_LO && m <= MONTH_SEASON_HI;
    endfunction

    function logic [SumW-1:0] rain_add(logic [SumW-1:0] a, logic [PrecW-1:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      return (s > RAIN_CEIL) ? SumW'(RAIN_CEIL) : SumW'(s);
    endfunction

    function logic [AlphaW-1:0] alpha_for(logic [CodeW-1:0] code);
      case (code)
        CLS_EF:                                return 8'd100;
        CLS_DSD, CLS_DWD:                      return 8'd115;
        CLS_CFC, CLS_DSA:                      return 8'd120;
        CLS_CSC, CLS_CWB, CLS_CWC, CLS_DWA:    return 8'd126;
        CLS_DFA, CLS_DFB, CLS_DWB:             return 8'd130;
        CLS_CWA:                               return 8'd137;
        CLS_AW:                                return 8'd140;
        CLS_CFA, CLS_CFB:                      return 8'd145;
        CLS_AM, CLS_CSA, CLS_CSB:              return 8'd165;
        CLS_BS:                                return 8'd185;
        CLS_AF, CLS_BW:                        return 8'd200;
        default:                               return 8'd110;
      endcase
    endfunction

    function verdict_t classify(bit north);
      longint       rain;
      longint       wet_s;
      longint       wet_w;
      longint       tsum;
      longint       pmin;
      longint       ofs;
      wet_letter_t  wet;
      heat_letter_t heat;
      verdict_t     v;
      rain  = rain_all;
      wet_s = rain_summer;
      wet_w = rain_winter;
      tsum  = t_total;
      pmin  = p_lo;
      if (3 * wet_w >= 2 * rain) v.regime = REGIME_WINTER;
      else if (3 * wet_s >= 2 * rain) v.regime = REGIME_SUMMER;
      else v.regime = REGIME_CONST;
      case (v.regime)
        REGIME_SUMMER: ofs = B_OFS_SUMMER;
        REGIME_WINTER: ofs = B_OFS_WINTER;
        default:       ofs = B_OFS_CONST;
      endcase
      if (t_hi < T_WARM) begin
        v.code = (t_hi < T_FROST) ? CLS_EF : CLS_ET;
      end else if (12 * rain < 2 * (tsum + ofs)) begin
        v.code = (12 * rain > tsum + ofs) ? CLS_BS : CLS_BW;
      end else if (t_lo >= T_TROP) begin
        if (p_lo >= P_WET) v.code = CLS_AF;
        else if (rain >= longint'(AM_LIMIT) - longint'(AM_SLOPE) * pmin) v.code = CLS_AM;
        else v.code = CLS_AW;
      end else begin
        if (north == in_season(p_lo_month))
          wet = (3 * pmin < longint'(peak_winter) && p_lo < P_DRY_SUM) ? LETTER_S : LETTER_F;
        else
          wet = (10 * pmin < longint'(peak_summer)) ? LETTER_W : LETTER_F;
        if (t_hi >= T_HOT) heat = LETTER_A;
        else if (warm_months >= WARM_MONTHS_B) heat = LETTER_B;
        else if (t_lo > T_SEVERE) heat = LETTER_C;
        else heat = LETTER_D;
        if (t_lo <= T_COLD) v.code = CodeW'(int'(CLS_DFA) + 4 * int'(wet) + int'(heat));
        else v.code = CodeW'(int'(CLS_CFA) + 3 * int'(wet) + int'(heat));
      end
      v.alpha = alpha_for(v.code);
      return v;
    endfunction

    function void note_word(logic [MonthW-1:0] m, logic signed [TempW-1:0] t,
                            logic [PrecW-1:0] p, logic [RowW-1:0] row);
      bit       north;
      longint   tsum;
      verdict_t v;
      north = (row <= ROW_NORTH_MAX);
      words++;
      if (t >= T_WARM && warm_months != COUNT_MAX) warm_months++;
      if (t < t_lo) t_lo = t;
      if (t > t_hi) t_hi = t;
      if (p < p_lo) begin
        p_lo       = p;
        p_lo_month = m;
      end
      tsum = longint'(t_total) + longint'(t);
      if (tsum > TSUM_MAX) tsum = TSUM_MAX;
      else if (tsum < TSUM_MIN) tsum = TSUM_MIN;
      t_total  = SumW'(tsum);
      rain_all = rain_add(rain_all, p);
      if (north == in_season(m)) begin
        rain_summer = rain_add(rain_summer, p);
        if (p > peak_summer) peak_summer = p;
      end else begin
        rain_winter = rain_add(rain_winter, p);
        if (p > peak_winter) peak_winter = p;
      end
      if (m != MONTH_LAST) return;
      v = classify(north);
      verdicts_due.push_back(v);
      seen_class[v.code] = 1'b1;
      clear();
    endfunction

    function void check_verdict(logic [CodeW-1:0] code, logic [AlphaW-1:0] alpha,
                                logic [RegimeW-1:0] regime);
      verdict_t due;
      checked++;
      if (verdicts_due.size() == 0) begin
        faults++;
        $display("%0t: result with none due: expected nothing, actual code %0d",
                 $time, code);
        $display("%0t:   actual alpha %0d regime %0d", $time, alpha, regime);
        return;
      end
      due = verdicts_due.pop_front();
      if (due.code !== code) begin
        faults++;
        $display("%0t: class_code expected %0d actual %0d", $time, due.code, code);
      end
      if (due.alpha !== alpha) begin
        faults++;
        $display("%0t: alpha_hundredths expected %0d actual %0d", $time, due.alpha, alpha);
      end
      if (due.regime !== regime) begin
        faults++;
        $display("%0t: rain_regime expected %0d actual %0d", $time, due.regime, regime);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function int distinct_classes();
      int n;
      n = 0;
      foreach (seen_class[i]) if (seen_class[i]) n++;
      return n;
    endfunction
  endclass

endpackage

FILE: bench/koppen_climate_classifier_tb.sv
`timescale 1ns / 1ps
// Testbench of the climate classifier: drives monthly words, idles both sides, checks results.
module koppen_climate_classifier_tb;
  import kcc_pkg::*;
  import climate_ledger_pkg::*;

  localparam int LATENCY     = 3;
  localparam int WORD_TARGET = 550;
  localparam int CALM_TAIL   = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SWING [12]  = '{-100, -87, -50, 0, 50, 87, 100, 87, 50, 0, -50, -87};

  typedef enum {RAIN_EVEN, RAIN_SUMMER, RAIN_WINTER} rain_style_t;
  typedef enum {RAGGED_NOISE, RAGGED_PARTIAL, RAGGED_EXTREME} ragged_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    valid = 1'b0;
  logic                    stall;
  logic [MonthW-1:0]       month = '0;
  logic signed [TempW-1:0] temperature = '0;
  logic [PrecW-1:0]        precipitation = '0;
  logic [RowW-1:0]         grid_row = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [CodeW-1:0]        class_code;
  logic [AlphaW-1:0]       alpha_hundredths;
  logic [RegimeW-1:0]      rain_regime;

  climate_ledger ledger;
  int            words_sent = 0;
  int            stall_left = 0;
  int unsigned   cycle_count = 0;
  bit            quiet = 1'b0;
  bit            paused = 1'b0;

  koppen_climate_classifier u_top (
    .clk(clk),
    .rst(rst),
    .valid(valid),
    .stall(stall),
    .month(month),
    .temperature(temperature),
    .precipitation(precipitation),
    .grid_row(grid_row),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .class_code(class_code),
    .alpha_hundredths(alpha_hundredths),
    .rain_regime(rain_regime)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (!rst) begin
      if (valid && !stall) ledger.note_word(month, temperature, precipitation, grid_row);
      if (result_valid && !result_stall)
        ledger.check_verdict(class_code, alpha_hundredths, rain_regime);
    end
  end

  always @(negedge clk) begin
    if (rst || quiet) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= result_stall ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_left   <= $urandom_range(1, 15);
    end
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic push_word(input int m, input int t, input int p, input int row);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    valid         <= 1'b1;
    month         <= MonthW'(m);
    temperature   <= TempW'(t);
    precipitation <= PrecW'(p);
    grid_row      <= RowW'(row);
    words_sent++;
    @(posedge clk);
    while (stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic climate_cell();
    int          row;
    int          hemi;
    int          mean;
    int          spread;
    int          wet;
    int          dry;
    int          t;
    int          p;
    rain_style_t style;
    row    = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 511))
                                          : int'($urandom_range(1, 360));
    hemi   = (row <= int'(ROW_NORTH_MAX)) ? 1 : -1;
    mean   = int'($urandom_range(0, 6500)) - 3500;
    spread = int'($urandom_range(0, 2500));
    wet    = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 500))
                                         : int'($urandom_range(0, 3500));
    dry    = int'($urandom_range(0, wet / 4));
    style  = rain_style_t'($urandom_range(0, 2));
    for (int m = 0; m < 12; m++) begin
      t = clip(mean + hemi * spread * SWING[m] / 100 + int'($urandom_range(0, 300)) - 150,
               -8192, 8191);
      case (style)
        RAIN_EVEN:   p = wet + int'($urandom_range(0, wet / 3 + 1));
        RAIN_SUMMER: p = (hemi * SWING[m] > 0) ? wet : dry;
        default:     p = (hemi * SWING[m] > 0) ? dry : wet;
      endcase
      push_word(m, t, p, row);
    end
  endtask

  task automatic ragged_run();
    ragged_t kind;
    int      n;
    int      row;
    int      t;
    kind = ragged_t'($urandom_range(0, 2));
    case (kind)
      RAGGED_NOISE: begin
        n = $urandom_range(1, 6);
        repeat (n)
          push_word($urandom_range(0, 15), int'($urandom_range(0, 16383)) - 8192,
                    $urandom_range(0, 32767), $urandom_range(0, 511));
      end
      RAGGED_PARTIAL: begin
        n   = $urandom_range(1, 14);
        row = $urandom_range(1, 360);
        repeat (n)
          push_word($urandom_range(0, 10), int'($urandom_range(0, 5000)) - 2000,
                    $urandom_range(0, 2500), row);
        push_word(MONTH_LAST, int'($urandom_range(0, 5000)) - 2000,
                  $urandom_range(0, 2500), row);
      end
      default: begin
        n   = $urandom_range(16, 20);
        t   = ($urandom_range(0, 1) == 0) ? 8191 : -8192;
        row = $urandom_range(0, 511);
        repeat (n)
          push_word($urandom_range(0, 10), t, ($urandom_range(0, 1) == 0) ? 32767 : 0, row);
        push_word(MONTH_LAST, t, 32767, row);
      end
    endcase
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timed out with %0d results outstanding", $time, ledger.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    ledger = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // months past the year, full-scale fields, rows off the grid, saturating sums
    for (int m = 12; m < 16; m++) push_word(m, 8191, 32767, 511);
    for (int m = 0; m < 11; m++) push_word(m, 8191, 32767, 0);
    push_word(5, 8191, 32767, 0);
    push_word(MONTH_LAST, 8191, 32767, 511);
    // short frozen cell with no rain at all
    push_word(0, -8192, 0, 181);
    push_word(MONTH_LAST, -8192, 0, 180);
    // dry month inside the season
    push_word(3, 2500, 100, 90);
    push_word(MONTH_LAST, 2500, 5000, 90);
    settle();

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 4) == 0) ragged_run();
      else climate_cell();
      if (!paused && words_sent >= WORD_TARGET / 2) begin
        settle();
        paused = 1'b1;
      end
      if (words_sent >= WORD_TARGET - CALM_TAIL) quiet = 1'b1;
    end
    settle();

    $display("run covered %0d words, %0d classifications, %0d distinct climate classes",
             ledger.words, ledger.checked, ledger.distinct_classes());
    if (ledger.faults == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
